FILE: hw/rtl/swp_pkg.sv
// Shared constants, types and register codes for the sliding-window percentile block.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
package swp_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int DATA_W     = 32;
  localparam int CFG_W      = 7;
  localparam int COUNT_W    = 7;
  localparam int AGE_W      = $clog2(WINDOW_MAX);
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

  localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = CFG_W'(64);
  localparam logic [CFG_W-1:0] PERCENT_RESET     = CFG_W'(50);
  localparam logic [CFG_W-1:0] PERCENT_FULL      = CFG_W'(100);

  // APB register map: index = paddr[ADDR_W-1:2]
  localparam int NUM_REGS = 2;
  localparam int IDX_W    = $clog2(NUM_REGS);
  localparam int ADDR_W   = IDX_W + 2;
  localparam logic [IDX_W-1:0] REG_WINDOW_SIZE = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_PERCENT     = IDX_W'(1);

  // Rank select: popcount chunks and divide-by-100 via reciprocal
  localparam int CHUNK      = (WINDOW_MAX < 8) ? WINDOW_MAX : 8;
  localparam int NUM_CHUNKS = (WINDOW_MAX + CHUNK - 1) / CHUNK;
  localparam int CHUNK_CW   = $clog2(CHUNK + 1);
  localparam int PROD_W     = CNT_W + CFG_W;
  localparam int RECIP_W    = 18;
  localparam int RECIP_SH   = 24;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(167773);  // ceil(2^24 / 100)
  localparam int RANK_PROD_W = PROD_W + RECIP_W;
  localparam int RANK_LAT   = 4;
  localparam int LAT_W      = $clog2(RANK_LAT + 1);

  // What one cell shows its neighbors and the rank logic
  typedef struct packed {
    logic              valid;
    logic              evict;     // holds the oldest sample, leaving this step
    logic              above_ev;  // sits after the leaving cell in order
    logic              gt_new;    // value strictly greater than the new sample
    logic [DATA_W-1:0] value;
    logic [AGE_W-1:0]  age;
  } swp_link_t;

endpackage

FILE: hw/rtl/swp_ifs.sv
// Valid/ready channel interfaces for samples in and percentile results out.
// Depends on swp_pkg for field widths.
interface swp_in_if;
  logic                      valid;
  logic                      ready;
  logic signed [swp_pkg::DATA_W-1:0] price;

  modport source(output valid, output price, input ready);
  modport sink(input valid, input price, output ready);
endinterface

interface swp_out_if;
  logic                      valid;
  logic                      ready;
  logic signed [swp_pkg::DATA_W-1:0] percentile_value;
  logic [swp_pkg::COUNT_W-1:0]       window_count;

  modport source(output valid, output percentile_value, output window_count, input ready);
  modport sink(input valid, input percentile_value, input window_count, output ready);
endinterface

FILE: hw/rtl/swp_cfg.sv
// APB register file: window_size and percent, with clamped effective values.
// Depends on swp_pkg.
module swp_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swp_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [swp_pkg::CNT_W-1:0]   ws_eff,
  output logic [swp_pkg::CFG_W-1:0]   pc_eff
);

  logic [swp_pkg::CFG_W-1:0] window_size;
  logic [swp_pkg::CFG_W-1:0] percent;
  logic [swp_pkg::IDX_W-1:0] reg_idx;
  logic                      wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[swp_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swp_pkg::WINDOW_SIZE_RESET;
      percent     <= swp_pkg::PERCENT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        swp_pkg::REG_WINDOW_SIZE: window_size <= pwdata[swp_pkg::CFG_W-1:0];
        swp_pkg::REG_PERCENT:     percent     <= pwdata[swp_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      swp_pkg::REG_WINDOW_SIZE: prdata = 32'(window_size);
      swp_pkg::REG_PERCENT:     prdata = 32'(percent);
      default:                  prdata = '0;
    endcase
  end

  // zero acts as one, oversize saturates at the history depth
  always_comb begin
    if (window_size == '0) begin
      ws_eff = swp_pkg::CNT_W'(1);
    end else if (32'(window_size) > 32'(swp_pkg::WINDOW_MAX)) begin
      ws_eff = swp_pkg::CNT_W'(swp_pkg::WINDOW_MAX);
    end else begin
      ws_eff = swp_pkg::CNT_W'(window_size);
    end
  end

  assign pc_eff = (percent > swp_pkg::PERCENT_FULL) ? swp_pkg::PERCENT_FULL : percent;

endmodule

FILE: hw/rtl/swp_cell.sv
// One cell of the sorted history chain: a sample and its age.
// Depends on swp_pkg; neighbors exchange swp_link_t every cycle.
module swp_cell (
  input  logic                         clk,
  input  logic                         load,
  input  logic                         valid,
  input  logic                         evicting,
  input  logic [swp_pkg::DATA_W-1:0]   new_value,
  input  logic [swp_pkg::DATA_W-1:0]   ev_value,
  input  swp_pkg::swp_link_t           left,
  input  swp_pkg::swp_link_t           right,
  output swp_pkg::swp_link_t           link
);

  logic [swp_pkg::DATA_W-1:0] value;
  logic [swp_pkg::AGE_W-1:0]  age;
  logic [swp_pkg::DATA_W-1:0] value_next;
  logic [swp_pkg::AGE_W-1:0]  age_next;
  logic is_ev, above_ev, gt_new;
  logic from_self, from_right, from_left;

  // order is (value ascending, age descending); the leaving cell is the
  // oldest, so it comes first among equal values
  assign gt_new   = valid && ($signed(value) > $signed(new_value));
  assign is_ev    = evicting && valid && (age == swp_pkg::AGE_W'(swp_pkg::WINDOW_MAX - 1));
  assign above_ev = evicting && valid && !is_ev && ($signed(value) >= $signed(ev_value));

  assign link = '{valid: valid, evict: is_ev, above_ev: above_ev, gt_new: gt_new,
                  value: value, age: age};

  // final slot of a kept cell = index - above_ev + gt_new
  assign from_self  = valid && !is_ev && (above_ev == gt_new);
  assign from_right = right.above_ev && !right.gt_new;
  assign from_left  = left.gt_new && !left.above_ev && !left.evict;

  always_comb begin
    if (from_self) begin
      value_next = value;
      age_next   = age + swp_pkg::AGE_W'(1);
    end else if (from_right) begin
      value_next = right.value;
      age_next   = right.age + swp_pkg::AGE_W'(1);
    end else if (from_left) begin
      value_next = left.value;
      age_next   = left.age + swp_pkg::AGE_W'(1);
    end else begin
      value_next = new_value;
      age_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value <= value_next;
      age   <= age_next;
    end
  end

endmodule

FILE: hw/rtl/swp_rank.sv
// Rank select over the cell chain: window mask, chunk popcounts, rank, one-hot pick.
// Depends on swp_pkg; free-running stages over a chain that holds still while busy.
module swp_rank (
  input  logic                        clk,
  input  swp_pkg::swp_link_t          cells [swp_pkg::WINDOW_MAX],
  input  logic [swp_pkg::CNT_W-1:0]   n,
  input  logic [swp_pkg::CFG_W-1:0]   pc,
  output logic [swp_pkg::DATA_W-1:0]  result,
  output logic [swp_pkg::DATA_W-1:0]  oldest_value
);

  logic [swp_pkg::WINDOW_MAX-1:0]   w_q;
  logic [swp_pkg::CHUNK_CW-1:0]     chunk_cnt_q [swp_pkg::NUM_CHUNKS];
  logic [swp_pkg::PROD_W-1:0]       prod_q;
  logic [swp_pkg::CNT_W-1:0]        base_q [swp_pkg::NUM_CHUNKS];
  logic [swp_pkg::CNT_W-1:0]        rank_q;
  logic [swp_pkg::WINDOW_MAX-1:0]   w2_q;
  logic [swp_pkg::WINDOW_MAX-1:0]   sel_q;

  // stage 1: in-window mask, per-chunk counts, (n-1)*pc
  always_ff @(posedge clk) begin
    logic [swp_pkg::CHUNK_CW-1:0] cnt;
    logic                         w;
    int                           idx;
    for (int k = 0; k < swp_pkg::NUM_CHUNKS; k++) begin
      cnt = '0;
      for (int j = 0; j < swp_pkg::CHUNK; j++) begin
        idx = k * swp_pkg::CHUNK + j;
        if (idx < swp_pkg::WINDOW_MAX) begin
          w = cells[idx].valid && (swp_pkg::CNT_W'(cells[idx].age) < n);
          w_q[idx] <= w;
          cnt = cnt + swp_pkg::CHUNK_CW'(w);
        end
      end
      chunk_cnt_q[k] <= cnt;
    end
    prod_q <= swp_pkg::PROD_W'(n - swp_pkg::CNT_W'(1)) * swp_pkg::PROD_W'(pc);
  end

  // stage 2: chunk base counts, rank = prod / 100
  always_ff @(posedge clk) begin
    logic [swp_pkg::CNT_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < swp_pkg::NUM_CHUNKS; k++) begin
      base_q[k] <= acc;
      acc = acc + swp_pkg::CNT_W'(chunk_cnt_q[k]);
    end
    rank_q <= swp_pkg::CNT_W'((swp_pkg::RANK_PROD_W'(prod_q) *
                               swp_pkg::RANK_PROD_W'(swp_pkg::RECIP)) >> swp_pkg::RECIP_SH);
    w2_q <= w_q;
  end

  // stage 3: one-hot select of the in-window cell whose count below equals rank
  always_ff @(posedge clk) begin
    logic [swp_pkg::CNT_W-1:0] acc;
    int                        idx;
    for (int k = 0; k < swp_pkg::NUM_CHUNKS; k++) begin
      acc = base_q[k];
      for (int j = 0; j < swp_pkg::CHUNK; j++) begin
        idx = k * swp_pkg::CHUNK + j;
        if (idx < swp_pkg::WINDOW_MAX) begin
          sel_q[idx] <= w2_q[idx] && (acc == rank_q);
          acc = acc + swp_pkg::CNT_W'(w2_q[idx]);
        end
      end
    end
  end

  // stage 4: pick; oldest-sample capture runs alongside for the next eviction
  always_ff @(posedge clk) begin
    logic [swp_pkg::DATA_W-1:0] pick;
    logic [swp_pkg::DATA_W-1:0] old;
    pick = '0;
    old  = '0;
    for (int i = 0; i < swp_pkg::WINDOW_MAX; i++) begin
      pick = pick | (cells[i].value & {swp_pkg::DATA_W{sel_q[i]}});
      old  = old | (cells[i].value & {swp_pkg::DATA_W{cells[i].valid &&
             (cells[i].age == swp_pkg::AGE_W'(swp_pkg::WINDOW_MAX - 1))}});
    end
    result       <= pick;
    oldest_value <= old;
  end

endmodule

FILE: hw/rtl/sliding_window_percentile.sv
// Top level of the sliding-window percentile filter: cell chain, rank select, APB regs.
// Depends on swp_pkg, swp_ifs (channel interfaces), swp_cfg, swp_cell and swp_rank.
//
//   channel   dir  payload                              handshake
//   samples   in   price (s32)                          valid/ready
//   results   out  percentile_value (s32), window_count valid/ready
//   apb       in   window_size @0x0, percent @0x4       psel/penable, pready=1
//
// One request at a time: the chain inserts/evicts at the accept edge, then the
// rank select runs 4 registered stages, then the result lands in the output
// register.
// samples.ready drops from accept until the result is loaded; a full output
// register stalls the load, not the accept of the next request once loaded.
// rst (synchronous) empties the history (fill count 0) and sets window_size 64,
// percent 50; cell contents are not cleared, only the fill count gates them.
module sliding_window_percentile (
  input  logic                        clk,
  input  logic                        rst,
  swp_in_if.sink                      samples,
  swp_out_if.source                   results,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swp_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [swp_pkg::CNT_W-1:0] ws_eff;
  logic [swp_pkg::CFG_W-1:0] pc_eff;
  logic [swp_pkg::CNT_W-1:0] fill;
  logic [swp_pkg::CNT_W-1:0] n;
  logic                      busy;
  logic [swp_pkg::LAT_W-1:0] lat_cnt;
  logic                      accept;
  logic                      evicting;
  logic                      load_out;
  logic [swp_pkg::DATA_W-1:0] rank_result;
  logic [swp_pkg::DATA_W-1:0] oldest_value;
  logic [swp_pkg::WINDOW_MAX-1:0] ev_bits;

  swp_pkg::swp_link_t links [swp_pkg::WINDOW_MAX];

  swp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ws_eff  (ws_eff),
    .pc_eff  (pc_eff)
  );

  assign samples.ready = !busy;
  assign accept        = samples.valid && samples.ready;
  // history full: the oldest sample (age WINDOW_MAX-1) leaves as the new one enters
  assign evicting      = (fill == swp_pkg::CNT_W'(swp_pkg::WINDOW_MAX));

  // cell chain, kept ascending by value; slots at or above fill are empty
  for (genvar i = 0; i < swp_pkg::WINDOW_MAX; i++) begin : g_cell
    swp_pkg::swp_link_t left_l;
    swp_pkg::swp_link_t right_l;
    if (i == 0) begin : g_lo
      assign left_l = '0;
    end else begin : g_lo_n
      assign left_l = links[i-1];
    end
    if (i == swp_pkg::WINDOW_MAX - 1) begin : g_hi
      assign right_l = '0;
    end else begin : g_hi_n
      assign right_l = links[i+1];
    end
    swp_cell u_cell (
      .clk       (clk),
      .load      (accept),
      .valid     (swp_pkg::CNT_W'(i) < fill),
      .evicting  (evicting),
      .new_value (samples.price),
      .ev_value  (oldest_value),
      .left      (left_l),
      .right     (right_l),
      .link      (links[i])
    );
    assign ev_bits[i] = links[i].evict;
  end

  // window holds the newest min(fill, window_size) samples
  assign n = (fill < ws_eff) ? fill : ws_eff;

  swp_rank u_rank (
    .clk          (clk),
    .cells        (links),
    .n            (n),
    .pc           (pc_eff),
    .result       (rank_result),
    .oldest_value (oldest_value)
  );

  // result is ready once the rank pipeline has seen the updated chain
  assign load_out = busy && (lat_cnt == swp_pkg::LAT_W'(swp_pkg::RANK_LAT)) &&
                    (!results.valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      busy          <= 1'b0;
      lat_cnt       <= '0;
      results.valid <= 1'b0;
    end else begin
      if (accept) begin
        busy    <= 1'b1;
        lat_cnt <= '0;
        if (!evicting) begin
          fill <= fill + swp_pkg::CNT_W'(1);
        end
      end else if (busy && lat_cnt != swp_pkg::LAT_W'(swp_pkg::RANK_LAT)) begin
        lat_cnt <= lat_cnt + swp_pkg::LAT_W'(1);
      end else if (load_out) begin
        busy <= 1'b0;
      end
      if (load_out) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      results.percentile_value <= rank_result;
      results.window_count     <= swp_pkg::COUNT_W'(n);
    end
  end

  // history never overfills
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= swp_pkg::CNT_W'(swp_pkg::WINDOW_MAX))
    else $error("fill count above history depth");

  // a full history has exactly one oldest sample to evict
  a_one_oldest: assert property (@(posedge clk) disable iff (rst)
    evicting |-> $countones(ev_bits) == 1)
    else $error("full history without a unique oldest cell");

  // an accepted request keeps the block busy until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !load_out)
    else $error("accepted request not held busy");

  // a result appears only from a busy pipeline at full latency
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(busy) &&
      $past(lat_cnt) == swp_pkg::LAT_W'(swp_pkg::RANK_LAT))
    else $error("result loaded outside of a finished request");

endmodule

FILE: tb/sv/tb_sliding_window_percentile.sv
`timescale 1ns / 100ps
// Self-checking testbench for sliding_window_percentile: random and directed price streams
// over valid/ready channels, APB writes for window_size and percent, scoreboarded results.
// Depends on swp_pkg and the swp_in_if / swp_out_if interfaces of the RTL.
module tb_sliding_window_percentile;

  // Generous, even for the slow phases
  localparam int CYCLE_LIMIT = 400000;
  // Settle after the last request, longer than a request spends inside the block
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS   = 90;

  localparam logic signed [swp_pkg::DATA_W-1:0] PRICE_MIN = 32'sh8000_0000;
  localparam logic signed [swp_pkg::DATA_W-1:0] PRICE_MAX = 32'sh7FFF_FFFF;

  typedef logic signed [swp_pkg::DATA_W-1:0] price_t;

  typedef struct packed {
    logic signed [swp_pkg::DATA_W-1:0] value;
    logic [swp_pkg::COUNT_W-1:0]       count;
  } percentile_t;

  logic clk = 1'b0;
  logic rst;

  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [swp_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  swp_in_if  samples_if ();
  swp_out_if results_if ();

  sliding_window_percentile i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if.sink),
    .results (results_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Prices waiting to be offered, filled by the sequence below
  price_t      queued_prices[$];
  // Newest WINDOW_MAX prices in arrival order: the history the block holds
  price_t      price_history[$];
  percentile_t expected_percentiles[$];

  // Shadow of the register file, updated when the APB write lands
  logic [swp_pkg::CFG_W-1:0] window_setting  = swp_pkg::WINDOW_SIZE_RESET;
  logic [swp_pkg::CFG_W-1:0] percent_setting = swp_pkg::PERCENT_RESET;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        price_taken;
  int          fail_count  = 0;
  int          cycle_count = 0;

  // Percentile of the newest n prices, n = min(held, effective window size).
  // Sorting a fresh copy of the window each time keeps this independent of
  // the age-tagged ordered chain the block maintains.
  function automatic percentile_t predict_percentile(input price_t price);
    price_t      ordered[$];
    percentile_t res;
    int          win;
    int          pct;
    int          n;
    int          rank;
    int          pos;
    price_history.insert(price_history.size(), price);
    if (price_history.size() > swp_pkg::WINDOW_MAX) begin
      void'(price_history.pop_front());
    end
    // zero window acts as one, oversize saturates; percent saturates at 100
    win = (window_setting == 0) ? 1 : int'(window_setting);
    if (win > swp_pkg::WINDOW_MAX) win = swp_pkg::WINDOW_MAX;
    pct = int'(percent_setting);
    if (pct > int'(swp_pkg::PERCENT_FULL)) pct = int'(swp_pkg::PERCENT_FULL);
    n = (price_history.size() < win) ? price_history.size() : win;
    for (int i = price_history.size() - n; i < price_history.size(); i++) begin
      pos = 0;
      while (pos < ordered.size() && ordered[pos] <= price_history[i]) pos++;
      ordered.insert(pos, price_history[i]);
    end
    rank = ((n - 1) * pct) / int'(swp_pkg::PERCENT_FULL);
    res.value = ordered[rank];
    res.count = swp_pkg::COUNT_W'(n);
    return res;
  endfunction

  // Mix of full-range values, a narrow band that forces ties, and the extremes
  function automatic price_t random_price();
    price_t p;
    case ($urandom_range(0, 9))
      5, 6, 7: p = price_t'(int'($urandom_range(0, 16)) - 8);
      8: begin
        case ($urandom_range(0, 3))
          0:       p = PRICE_MIN;
          1:       p = PRICE_MAX;
          2:       p = '0;
          default: p = '1;
        endcase
      end
      default: p = price_t'($urandom());
    endcase
    return p;
  endfunction

  // Sender: a new request goes out only once the previous one was taken.
  // price_taken is registered at the rising edge, so it is stable here.
  always @(negedge clk) begin
    if (rst) begin
      samples_if.valid <= 1'b0;
    end else if (!samples_if.valid || price_taken) begin
      if (queued_prices.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        samples_if.valid <= 1'b1;
        samples_if.price <= queued_prices.pop_front();
      end else begin
        samples_if.valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, rerolled every cycle
  always @(negedge clk) begin
    results_if.ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Predict on every accepted request, check every accepted result in order
  always @(posedge clk) begin
    percentile_t want;
    price_taken <= !rst && samples_if.valid && samples_if.ready;
    if (!rst && samples_if.valid && samples_if.ready) begin
      expected_percentiles.insert(expected_percentiles.size(),
                                  predict_percentile(samples_if.price));
    end
    if (!rst && results_if.valid && results_if.ready) begin
      if (expected_percentiles.size() == 0) begin
        $error("unexpected result: percentile_value %0d, window_count %0d",
               results_if.percentile_value, results_if.window_count);
        fail_count++;
      end else begin
        want = expected_percentiles.pop_front();
        if (results_if.percentile_value !== want.value) begin
          $error("percentile_value: expected %0d, got %0d",
                 want.value, results_if.percentile_value);
          fail_count++;
        end
        if (results_if.window_count !== want.count) begin
          $error("window_count: expected %0d, got %0d", want.count, results_if.window_count);
          fail_count++;
        end
      end
    end
  end

  // Two-phase APB write; the register takes the value at the access edge.
  // Upper data bits are noise: only the low CFG_W bits are kept.
  task automatic write_register(input logic [swp_pkg::IDX_W-1:0] index,
                                input int unsigned setting);
    logic [swp_pkg::CFG_W-1:0] field;
    field = swp_pkg::CFG_W'(setting);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= {(32 - swp_pkg::CFG_W)'($urandom()), field};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (index == swp_pkg::REG_WINDOW_SIZE) begin
      window_setting = field;
    end else begin
      percent_setting = field;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Sender holds off until every request is answered, then the pipe settles.
  // Checked at the rising edge, where the scoreboard has already been updated.
  task automatic wait_drained();
    while (queued_prices.size() != 0 || samples_if.valid || expected_percentiles.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    int unsigned win_pick;
    int unsigned pct_pick;
    rst              = 1'b1;
    samples_if.valid = 1'b0;
    samples_if.price = '0;
    results_if.ready = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    set_idling(26, 85);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset registers (window 64, median), extremes and ties
    queued_prices = '{PRICE_MIN, PRICE_MAX, 0, -1, 1, 7, 7, 7, PRICE_MAX, PRICE_MIN};
    wait_drained();

    // zero window behaves as a window of one
    write_register(swp_pkg::REG_WINDOW_SIZE, 0);
    queued_prices = '{PRICE_MIN, PRICE_MAX, 3};
    wait_drained();

    // oversize window and percent above hundred both saturate
    write_register(swp_pkg::REG_WINDOW_SIZE, 127);
    write_register(swp_pkg::REG_PERCENT, 127);
    queued_prices = '{-5, 9, 0};
    wait_drained();

    // shrinking the window mid-stream, lowest rank
    write_register(swp_pkg::REG_WINDOW_SIZE, 2);
    write_register(swp_pkg::REG_PERCENT, 0);
    queued_prices = '{4, -4};
    wait_drained();

    // growing it again reuses samples still held, highest rank
    write_register(swp_pkg::REG_WINDOW_SIZE, 64);
    write_register(swp_pkg::REG_PERCENT, 100);
    queued_prices = '{1, -1};
    wait_drained();

    // Random phases; every boundary is a full drain before the next config
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase / 3)
        0:       set_idling(26, 85);
        1:       set_idling(85, 26);
        default: set_idling(0, 0);
      endcase
      case (phase)
        0:       begin win_pick = 64;                      pct_pick = $urandom_range(0, 100); end
        1:       begin win_pick = 1;                       pct_pick = 100;                    end
        2:       begin win_pick = 127;                     pct_pick = 0;                      end
        3:       begin win_pick = 0;                       pct_pick = 127;                    end
        4:       begin win_pick = 2;                       pct_pick = 50;                     end
        5:       begin win_pick = $urandom_range(1, 64);   pct_pick = $urandom_range(0, 127); end
        6:       begin win_pick = 64;                      pct_pick = 99;                     end
        7:       begin win_pick = $urandom_range(65, 127); pct_pick = 1;                      end
        default: begin win_pick = $urandom_range(3, 63);   pct_pick = $urandom_range(0, 100); end
      endcase
      write_register(swp_pkg::REG_WINDOW_SIZE, win_pick);
      write_register(swp_pkg::REG_PERCENT, pct_pick);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        queued_prices.insert(queued_prices.size(), random_price());
      end
      wait_drained();
    end

    if (expected_percentiles.size() != 0) begin
      $error("%0d results never arrived", expected_percentiles.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
